// ===== sv/hurpp_pkg.sv =====
`timescale 1ns / 1ps

package hurpp_pkg;

	localparam int ANGLE_BITS   = 16;
	localparam int COORD_BITS   = 24;

	// CORDIC datapath
	localparam int CORDIC_STEPS = 28;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int XY_W         = 33;
	localparam int Z_W          = 33;
	localparam int TURN_W       = 32;
	localparam int ATAN_W       = 30;
	localparam longint CORDIC_GAIN_Q30 = 652032874;

	// sin/cos rounded to Q16
	localparam int SC_W         = 18;
	localparam int SC_SHIFT     = 14;
	localparam longint SC_HALF  = 64'd1 << (SC_SHIFT - 1);

	// offsets and products
	localparam int DIF_W        = COORD_BITS + 1;
	localparam int PROD_W       = DIF_W + SC_W;
	localparam int U_W          = (PROD_W + 1 > 44) ? PROD_W + 1 : 44;
	localparam int MAG_W        = 43;
	localparam longint OFFSET_LIMIT = 64'sd1 << (MAG_W - 1);

	// configuration
	localparam int XY_CFG_W     = 16;
	localparam int VHR_W        = 16;
	localparam int WPR_W        = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;

	// scaling: q = floor(((mag*vhr + wpr*2^14) >> 15) / wpr)
	localparam int HALF_SHIFT   = 14;
	localparam int DEN_SHIFT    = 15;
	localparam int PRODV_W      = MAG_W + VHR_W + 1;
	localparam int NN_W         = PRODV_W - DEN_SHIFT;
	localparam int Q_W          = VHR_W + 1;
	localparam int K_W          = $clog2(Q_W);
	localparam int DIV_W        = WPR_W + Q_W;

	localparam int PLOT_W       = 18;
	localparam int COLOR_W      = 32;
	localparam int KIND_W       = 8;
	localparam int HDG_W        = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X        = 3'd0,
		REG_CENTER_Y        = 3'd1,
		REG_VIEW_HALF_RANGE = 3'd2,
		REG_WORLD_PER_RADAR = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [KIND_W-1:0]  kind;
		logic [HDG_W-1:0]   heading;
	} pass_t;

	typedef struct packed {
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [Z_W-1:0]   z;
		logic                    flip;
		logic signed [DIF_W-1:0] dx;
		logic signed [DIF_W-1:0] dy;
		pass_t                   pass;
	} cordic_item_t;

	// lane 0 is the horizontal offset, lane 1 the negated vertical one
	typedef struct packed {
		logic [1:0][DIV_W-1:0] rem;
		logic [1:0][Q_W-1:0]   quo;
		logic [1:0]            ovf;
		logic [1:0]            neg;
		pass_t                 pass;
	} div_item_t;

	// atan(2^-i) in 32-bit binary turns
	function automatic logic [ATAN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [ATAN_W-1:0] r;
		case (i)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670163;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/hurpp_cordic_cell.sv =====
`timescale 1ns / 1ps

module hurpp_cordic_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [hurpp_pkg::STEP_W-1:0] step,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  hurpp_pkg::cordic_item_t     in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hurpp_pkg::cordic_item_t     out_item
);
	import hurpp_pkg::*;

	logic                   valid_q;
	cordic_item_t           item_q;
	cordic_item_t           nxt;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  ang;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	// one micro-rotation, floor shifts
	always_comb begin
		nxt = in_item;
		xs  = in_item.x >>> step;
		ys  = in_item.y >>> step;
		ang = $signed({{(Z_W-ATAN_W){1'b0}}, atan_turn(step)});
		if (!in_item.z[Z_W-1]) begin
			nxt.x = in_item.x - ys;
			nxt.y = in_item.y + xs;
			nxt.z = in_item.z - ang;
		end else begin
			nxt.x = in_item.x + ys;
			nxt.y = in_item.y - xs;
			nxt.z = in_item.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= nxt;
		end
	end

endmodule

// ===== sv/hurpp_div_cell.sv =====
`timescale 1ns / 1ps

module hurpp_div_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [hurpp_pkg::K_W-1:0]     bit_pos,
	input  logic [hurpp_pkg::WPR_W-1:0]   divisor,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  hurpp_pkg::div_item_t          in_item,
	output logic                          out_valid,
	input  logic                          out_ready,
	output hurpp_pkg::div_item_t          out_item
);
	import hurpp_pkg::*;

	logic             valid_q;
	div_item_t        item_q;
	div_item_t        nxt;
	logic [DIV_W-1:0] den;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	// restoring step, both lanes
	always_comb begin
		nxt = in_item;
		den = DIV_W'(divisor) << bit_pos;
		for (int l = 0; l < 2; l++) begin
			if (in_item.rem[l] >= den) begin
				nxt.rem[l]          = in_item.rem[l] - den;
				nxt.quo[l][bit_pos] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= nxt;
		end
	end

endmodule

// ===== sv/heading_up_radar_plot_projection_core.sv =====
`timescale 1ns / 1ps
// Heading-up radar plot projection.
// Input channel (in_valid/in_ready): one item per target with observer position
// and heading, target position and the color/kind/heading that ride along.
// Output channel (out_valid/out_ready): screen position of the target plus the
// passthrough fields. Targets outside the square of half side view_half_range
// around the center produce no item.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): registers center_x,
// center_y, view_half_range, world_per_radar; cfg_ready is always high. Write
// only while no item is in flight.
// Pipeline: 28 CORDIC cells, five multiply/scale stages, 17 divider cells and
// an output register. Throughput: one item per cycle while out_ready is high;
// every cell carries a single item and hands it on. Each cell keeps its own
// valid bit and is ready when empty or when its downstream is ready, so a
// stalled receiver backs the chain up cell by cell while empty cells keep
// filling. Reset clears all valid bits and loads the register defaults
// (view_half_range 1600, world_per_radar 2560000).
module heading_up_radar_plot_projection_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hurpp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hurpp_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [hurpp_pkg::COORD_BITS-1:0] observer_x,
	input  logic signed [hurpp_pkg::COORD_BITS-1:0] observer_y,
	input  logic [hurpp_pkg::ANGLE_BITS-1:0]     observer_heading,
	input  logic signed [hurpp_pkg::COORD_BITS-1:0] target_x,
	input  logic signed [hurpp_pkg::COORD_BITS-1:0] target_y,
	input  logic [hurpp_pkg::COLOR_W-1:0]        target_color,
	input  logic [hurpp_pkg::KIND_W-1:0]         target_kind,
	input  logic [hurpp_pkg::HDG_W-1:0]          target_heading,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [hurpp_pkg::PLOT_W-1:0]  plot_x,
	output logic signed [hurpp_pkg::PLOT_W-1:0]  plot_y,
	output logic [hurpp_pkg::COLOR_W-1:0]        plot_color,
	output logic [hurpp_pkg::KIND_W-1:0]         plot_kind,
	output logic [hurpp_pkg::HDG_W-1:0]          plot_heading
);
	import hurpp_pkg::*;

	// ---------------- configuration registers ----------------
	logic [XY_CFG_W-1:0] center_x_q;
	logic [XY_CFG_W-1:0] center_y_q;
	logic [VHR_W-1:0]    vhr_q;
	logic [WPR_W-1:0]    wpr_q;     // zero span is stored as one

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			vhr_q      <= VHR_W'(1600);
			wpr_q      <= WPR_W'(2560000);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:        center_x_q <= cfg_data[XY_CFG_W-1:0];
				REG_CENTER_Y:        center_y_q <= cfg_data[XY_CFG_W-1:0];
				REG_VIEW_HALF_RANGE: vhr_q      <= cfg_data[VHR_W-1:0];
				REG_WORLD_PER_RADAR: begin
					wpr_q <= (cfg_data[WPR_W-1:0] == '0) ? WPR_W'(1) : cfg_data[WPR_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// ---------------- angle fold and offsets ----------------
	// Fold the heading into [-1/4, 1/4) turn; a half turn taken off flips the sign.
	logic [TURN_W-1:0] turn;
	logic              flip;
	logic [TURN_W-1:0] turn_f;
	cordic_item_t      head_item;

	always_comb begin
		turn   = {observer_heading, {(TURN_W-ANGLE_BITS){1'b0}}};
		flip   = turn[TURN_W-1] ^ turn[TURN_W-2];
		turn_f = flip ? {~turn[TURN_W-1], turn[TURN_W-2:0]} : turn;
		head_item.x    = XY_W'(CORDIC_GAIN_Q30);
		head_item.y    = '0;
		head_item.z    = $signed({turn_f[TURN_W-1], turn_f});
		head_item.flip = flip;
		head_item.dx   = DIF_W'(target_x) - DIF_W'(observer_x);
		head_item.dy   = DIF_W'(target_y) - DIF_W'(observer_y);
		head_item.pass = '{color: target_color, kind: target_kind, heading: target_heading};
	end

	// ---------------- CORDIC chain ----------------
	logic         cv_valid [CORDIC_STEPS+1];
	logic         cv_ready [CORDIC_STEPS+1];
	cordic_item_t cv_item  [CORDIC_STEPS+1];

	assign cv_valid[0] = in_valid;
	assign cv_item[0]  = head_item;
	assign in_ready    = cv_ready[0];

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		hurpp_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (STEP_W'(i)),
			.in_valid  (cv_valid[i]),
			.in_ready  (cv_ready[i]),
			.in_item   (cv_item[i]),
			.out_valid (cv_valid[i+1]),
			.out_ready (cv_ready[i+1]),
			.out_item  (cv_item[i+1])
		);
	end

	// ---------------- projection stages ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic                    div_valid [Q_W+1];
	logic                    div_ready [Q_W+1];
	div_item_t               div_item  [Q_W+1];

	assign rdy_s1 = !v_s1 || rdy_s2;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s5 = !v_s5 || div_ready[0];
	assign cv_ready[CORDIC_STEPS] = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= cv_valid[CORDIC_STEPS];
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// s1: undo fold, round to Q16
	cordic_item_t           cend;
	logic signed [XY_W-1:0] xf, yf;
	logic signed [XY_W-1:0] sr, cr;
	logic signed [SC_W-1:0] sin_s1, cos_s1;
	logic signed [DIF_W-1:0] dx_s1, dy_s1;
	pass_t                  pass_s1;

	always_comb begin
		cend = cv_item[CORDIC_STEPS];
		xf   = cend.flip ? -cend.x : cend.x;
		yf   = cend.flip ? -cend.y : cend.y;
		sr   = (yf + XY_W'(SC_HALF)) >>> SC_SHIFT;
		cr   = (xf + XY_W'(SC_HALF)) >>> SC_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (cv_valid[CORDIC_STEPS] && rdy_s1) begin
			sin_s1  <= sr[SC_W-1:0];
			cos_s1  <= cr[SC_W-1:0];
			dx_s1   <= cend.dx;
			dy_s1   <= cend.dy;
			pass_s1 <= cend.pass;
		end
	end

	// s2: four products
	logic signed [PROD_W-1:0] p_xs_s2, p_yc_s2, p_xc_s2, p_ys_s2;
	pass_t                    pass_s2;

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			p_xs_s2 <= dx_s1 * sin_s1;
			p_yc_s2 <= dy_s1 * cos_s1;
			p_xc_s2 <= dx_s1 * cos_s1;
			p_ys_s2 <= dy_s1 * sin_s1;
			pass_s2 <= pass_s1;
		end
	end

	// s3: u and -v, clamp, magnitude and sign
	function automatic logic [MAG_W:0] mag_of(input logic signed [U_W-1:0] w);
		logic signed [U_W-1:0] lim;
		logic signed [U_W-1:0] c;
		lim = U_W'(OFFSET_LIMIT);
		c   = w;
		if (w > lim)
			c = lim;
		else if (w < -lim)
			c = -lim;
		return {w[U_W-1], MAG_W'(w[U_W-1] ? -c : c)};
	endfunction

	logic signed [U_W-1:0] u_w, nv_w;
	logic [MAG_W:0]        mu, mv;
	logic [1:0][MAG_W-1:0] mag_s3;
	logic [1:0]            neg_s3;
	pass_t                 pass_s3;

	always_comb begin
		u_w  = U_W'(p_xs_s2) - U_W'(p_yc_s2);
		nv_w = -(U_W'(p_xc_s2) + U_W'(p_ys_s2));
		mu   = mag_of(u_w);
		mv   = mag_of(nv_w);
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy_s3) begin
			mag_s3[0] <= mu[MAG_W-1:0];
			mag_s3[1] <= mv[MAG_W-1:0];
			neg_s3    <= {mv[MAG_W], mu[MAG_W]};
			pass_s3   <= pass_s2;
		end
	end

	// s4: magnitude times view range
	logic [1:0][PRODV_W-1:0] prod_s4;
	logic [1:0]              neg_s4;
	pass_t                   pass_s4;

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			for (int l = 0; l < 2; l++) begin
				prod_s4[l] <= PRODV_W'(mag_s3[l]) * PRODV_W'(vhr_q);
			end
			neg_s4  <= neg_s3;
			pass_s4 <= pass_s3;
		end
	end

	// s5: add half divisor, drop low bits, flag quotients beyond 17 bits
	logic [1:0][PRODV_W-1:0] rsum;
	logic [1:0][NN_W-1:0]    nn;
	div_item_t               item_s5;

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rsum[l] = prod_s4[l] + (PRODV_W'(wpr_q) << HALF_SHIFT);
			nn[l]   = NN_W'(rsum[l] >> DEN_SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rdy_s5) begin
			for (int l = 0; l < 2; l++) begin
				item_s5.rem[l] <= nn[l][DIV_W-1:0];
				item_s5.ovf[l] <= nn[l] >= (NN_W'(wpr_q) << Q_W);
			end
			item_s5.quo  <= '0;
			item_s5.neg  <= neg_s4;
			item_s5.pass <= pass_s4;
		end
	end

	// ---------------- divider chain ----------------
	logic out_valid_q;
	logic last_ready;

	assign last_ready       = !out_valid_q || out_ready;
	assign div_valid[0]     = v_s5;
	assign div_item[0]      = item_s5;
	assign div_ready[Q_W]   = last_ready;

	for (genvar j = 0; j < Q_W; j++) begin : g_div
		hurpp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bit_pos   (K_W'(Q_W - 1 - j)),
			.divisor   (wpr_q),
			.in_valid  (div_valid[j]),
			.in_ready  (div_ready[j]),
			.in_item   (div_item[j]),
			.out_valid (div_valid[j+1]),
			.out_ready (div_ready[j+1]),
			.out_item  (div_item[j+1])
		);
	end

	// ---------------- clip and output register ----------------
	div_item_t                dlast;
	logic                     keep;
	logic signed [PLOT_W:0]   off_x, off_y, sum_x, sum_y;
	logic signed [PLOT_W-1:0] plot_x_q, plot_y_q;
	pass_t                    pass_q;

	always_comb begin
		dlast = div_item[Q_W];
		keep  = !dlast.ovf[0] && !dlast.ovf[1] &&
		        (dlast.quo[0] <= Q_W'(vhr_q)) && (dlast.quo[1] <= Q_W'(vhr_q));
		off_x = dlast.neg[0] ? -$signed((PLOT_W+1)'(dlast.quo[0]))
		                     :  $signed((PLOT_W+1)'(dlast.quo[0]));
		off_y = dlast.neg[1] ? -$signed((PLOT_W+1)'(dlast.quo[1]))
		                     :  $signed((PLOT_W+1)'(dlast.quo[1]));
		sum_x = $signed((PLOT_W+1)'(center_x_q)) + off_x;
		sum_y = $signed((PLOT_W+1)'(center_y_q)) + off_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_ready) begin
			out_valid_q <= div_valid[Q_W] && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (div_valid[Q_W] && keep && last_ready) begin
			plot_x_q <= sum_x[PLOT_W-1:0];
			plot_y_q <= sum_y[PLOT_W-1:0];
			pass_q   <= dlast.pass;
		end
	end

	assign out_valid    = out_valid_q;
	assign plot_x       = plot_x_q;
	assign plot_y       = plot_y_q;
	assign plot_color   = pass_q.color;
	assign plot_kind    = pass_q.kind;
	assign plot_heading = pass_q.heading;

	// ---------------- assertions ----------------
	// the x coordinate of a plotted point never leaves the clip square around the center
	a_clip_square: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			($signed(plot_x) - $signed({2'b00, center_x_q}) <= $signed({2'b00, vhr_q})) &&
			($signed({2'b00, center_x_q}) - $signed(plot_x) <= $signed({2'b00, vhr_q})))
		else $error("plot_x outside clip square");

	// an overflowed quotient is dropped, never loaded
	a_ovf_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(div_valid[Q_W] && last_ready && (dlast.ovf[0] || dlast.ovf[1])) |=> !out_valid)
		else $error("overflowed item reached output");

	// clamped magnitude stays within the offset limit
	a_mag_limit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (mag_s3[0] <= MAG_W'(OFFSET_LIMIT)) && (mag_s3[1] <= MAG_W'(OFFSET_LIMIT)))
		else $error("offset magnitude beyond clamp");

	// input backpressure only when the first cell holds an item
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> cv_valid[1])
		else $error("input stalled with empty first cell");

endmodule
